// ----- src/two_axis_dda_step_generator_top_assert.svh -----
// ----------------------------------------------------------------------------
// two-axis dda step generator assertion macros
// immediate-consequence and next-cycle property forms with reset disable
// ----------------------------------------------------------------------------
`ifndef TWO_AXIS_DDA_STEP_GENERATOR_TOP_ASSERT_SVH
`define TWO_AXIS_DDA_STEP_GENERATOR_TOP_ASSERT_SVH

// consequence holds in the same cycle as the antecedent
`define TADSG_ASSERT_NOW(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define TADSG_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/tadsg_pkg.sv -----
// ----------------------------------------------------------------------------
// tadsg_pkg
// shared types and constants of the two-axis dda step generator
// ----------------------------------------------------------------------------
package tadsg_pkg;

    localparam int STEP_BITS_DEF  = 24;
    localparam int POS_BITS_DEF   = 32;
    localparam int TIMER_BITS_DEF = 16;

    localparam int IN_STEP_W  = 24;
    localparam int OUT_POS_W  = 32;
    localparam int CFG_BITS   = 16;

    localparam logic [CFG_BITS-1:0] STEP_INTERVAL_RESET = 16'd625;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_MOVE = 1'b1;

    typedef struct packed {
        logic                        kind;
        logic signed [IN_STEP_W-1:0] steps_a;
        logic signed [IN_STEP_W-1:0] steps_b;
    } in_word_t;

    typedef struct packed {
        logic                        step_a;
        logic                        step_b;
        logic                        dir_a;
        logic                        dir_b;
        logic                        drive_enable;
        logic signed [OUT_POS_W-1:0] position_a;
        logic signed [OUT_POS_W-1:0] position_b;
        logic                        move_done;
        logic                        rejected;
    } out_word_t;

    typedef struct packed {
        logic                fire;
        logic [CFG_BITS-1:0] step_interval;
    } core_ctrl_t;

endpackage

// ----- src/two_axis_dda_step_generator_top.sv -----
// ----------------------------------------------------------------------------
// two_axis_dda_step_generator_top
// Two-axis dda step generator. Every input word (a timebase tick or a move
// command) yields exactly one output word with step strobes, directions,
// drive enable, positions and done/reject flags. One word is taken every
// clock cycle unless out_stall holds the output; a word passes an input
// register and the dda update, which lands in the output register.
// The rate is set by the registered state update loop of the accumulators
// and tick timer. The step interval register should be written only while
// no move is running and no word is in flight.
// ----------------------------------------------------------------------------
module two_axis_dda_step_generator_top #(
    parameter int STEP_BITS  = tadsg_pkg::STEP_BITS_DEF,
    parameter int POS_BITS   = tadsg_pkg::POS_BITS_DEF,
    parameter int TIMER_BITS = tadsg_pkg::TIMER_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  tadsg_pkg::in_word_t               in_word,
    output logic                              out_valid,
    input  logic                              out_stall,
    output tadsg_pkg::out_word_t              out_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tadsg_pkg::CFG_BITS-1:0]    cfg_data
);

    tadsg_pkg::in_word_t   in_word_reg;
    logic                  in_vld_reg;
    logic                  out_vld_reg;
    tadsg_pkg::out_word_t  out_word_reg;
    logic [tadsg_pkg::CFG_BITS-1:0] interval_reg;
    tadsg_pkg::core_ctrl_t ctrl;
    tadsg_pkg::out_word_t  result;
    logic                  advance;
    logic                  in_take;

    assign advance   = in_vld_reg & (~out_vld_reg | ~out_stall);
    assign in_stall  = in_vld_reg & ~advance;
    assign in_take   = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_vld_reg;
    assign out_word  = out_word_reg;

    assign ctrl.fire          = advance;
    assign ctrl.step_interval = interval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            interval_reg <= tadsg_pkg::STEP_INTERVAL_RESET;
        end
        else
        begin
            if (!in_vld_reg || advance)
            begin
                in_vld_reg <= in_take;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                interval_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_word_reg <= in_word;
        end
        if (advance)
        begin
            out_word_reg <= result;
        end
    end

    tadsg_core #(
        .STEP_BITS  (STEP_BITS),
        .POS_BITS   (POS_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .item   (in_word_reg),
        .result (result)
    );

endmodule

// ----- src/tadsg_core.sv -----
// ----------------------------------------------------------------------------
// tadsg_core
// move state, tick timer and per-axis dda accumulators; one word per fire
// ----------------------------------------------------------------------------
`include "two_axis_dda_step_generator_top_assert.svh"

module tadsg_core #(
    parameter int STEP_BITS  = tadsg_pkg::STEP_BITS_DEF,
    parameter int POS_BITS   = tadsg_pkg::POS_BITS_DEF,
    parameter int TIMER_BITS = tadsg_pkg::TIMER_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tadsg_pkg::core_ctrl_t ctrl,
    input  tadsg_pkg::in_word_t   item,
    output tadsg_pkg::out_word_t  result
);

    localparam int CMP_W = (TIMER_BITS + 1 > tadsg_pkg::CFG_BITS) ?
                           TIMER_BITS + 1 : tadsg_pkg::CFG_BITS;

    logic [POS_BITS-1:0]   pos_a_reg, pos_a_next;
    logic [POS_BITS-1:0]   pos_b_reg, pos_b_next;
    logic [STEP_BITS-1:0]  mag_a_reg, mag_a_next;
    logic [STEP_BITS-1:0]  mag_b_reg, mag_b_next;
    logic [STEP_BITS-1:0]  total_reg, total_next;
    logic [STEP_BITS-1:0]  iter_reg, iter_next;
    logic [STEP_BITS-1:0]  accum_a_reg, accum_a_next;
    logic [STEP_BITS-1:0]  accum_b_reg, accum_b_next;
    logic [TIMER_BITS-1:0] tick_reg, tick_next;
    logic                  dir_a_reg, dir_a_next;
    logic                  dir_b_reg, dir_b_next;
    logic                  busy_reg, busy_next;

    logic signed [STEP_BITS-1:0] ext_a, ext_b;
    logic [STEP_BITS-1:0]        in_mag_a, in_mag_b;
    logic [STEP_BITS-1:0]        sum_a, sum_b, iter_plus;
    logic [CMP_W-1:0]            tick_plus;
    logic                        sa, sb, done, rej;

    // sign handling of the move counts
    always_comb
    begin
        ext_a    = STEP_BITS'(item.steps_a);
        ext_b    = STEP_BITS'(item.steps_b);
        in_mag_a = ext_a[STEP_BITS-1] ? (~ext_a + 1'b1) : ext_a;
        in_mag_b = ext_b[STEP_BITS-1] ? (~ext_b + 1'b1) : ext_b;
    end

    always_comb
    begin
        pos_a_next   = pos_a_reg;
        pos_b_next   = pos_b_reg;
        mag_a_next   = mag_a_reg;
        mag_b_next   = mag_b_reg;
        total_next   = total_reg;
        iter_next    = iter_reg;
        accum_a_next = accum_a_reg;
        accum_b_next = accum_b_reg;
        tick_next    = tick_reg;
        dir_a_next   = dir_a_reg;
        dir_b_next   = dir_b_reg;
        busy_next    = busy_reg;
        sa           = 1'b0;
        sb           = 1'b0;
        done         = 1'b0;
        rej          = 1'b0;
        sum_a        = accum_a_reg + mag_a_reg;
        sum_b        = accum_b_reg + mag_b_reg;
        iter_plus    = iter_reg + 1'b1;
        tick_plus    = CMP_W'(tick_reg) + CMP_W'(1);

        if (ctrl.fire)
        begin
            if (item.kind == tadsg_pkg::KIND_MOVE)
            begin
                if (busy_reg)
                begin
                    rej = 1'b1;
                end
                else if (in_mag_a == '0 && in_mag_b == '0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    mag_a_next   = in_mag_a;
                    mag_b_next   = in_mag_b;
                    dir_a_next   = ~ext_a[STEP_BITS-1];
                    dir_b_next   = ~ext_b[STEP_BITS-1];
                    total_next   = (in_mag_a > in_mag_b) ? in_mag_a : in_mag_b;
                    iter_next    = '0;
                    accum_a_next = '0;
                    accum_b_next = '0;
                    tick_next    = '0;
                    busy_next    = 1'b1;
                end
            end
            else if (busy_reg)
            begin
                if (tick_plus >= CMP_W'(ctrl.step_interval))
                begin
                    tick_next = '0;
                    if (sum_a >= total_reg)
                    begin
                        accum_a_next = sum_a - total_reg;
                        sa           = 1'b1;
                        pos_a_next   = dir_a_reg ? pos_a_reg + 1'b1 : pos_a_reg - 1'b1;
                    end
                    else
                    begin
                        accum_a_next = sum_a;
                    end
                    if (sum_b >= total_reg)
                    begin
                        accum_b_next = sum_b - total_reg;
                        sb           = 1'b1;
                        pos_b_next   = dir_b_reg ? pos_b_reg + 1'b1 : pos_b_reg - 1'b1;
                    end
                    else
                    begin
                        accum_b_next = sum_b;
                    end
                    iter_next = iter_plus;
                    if (iter_plus >= total_reg)
                    begin
                        busy_next = 1'b0;
                        done      = 1'b1;
                    end
                end
                else
                begin
                    tick_next = TIMER_BITS'(tick_plus);
                end
            end
        end

        result.step_a       = sa;
        result.step_b       = sb;
        result.dir_a        = dir_a_next;
        result.dir_b        = dir_b_next;
        result.drive_enable = busy_reg | busy_next;
        result.position_a   = $signed(tadsg_pkg::OUT_POS_W'(pos_a_next));
        result.position_b   = $signed(tadsg_pkg::OUT_POS_W'(pos_b_next));
        result.move_done    = done;
        result.rejected     = rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_a_reg   <= '0;
            pos_b_reg   <= '0;
            mag_a_reg   <= '0;
            mag_b_reg   <= '0;
            total_reg   <= '0;
            iter_reg    <= '0;
            accum_a_reg <= '0;
            accum_b_reg <= '0;
            tick_reg    <= '0;
            dir_a_reg   <= 1'b0;
            dir_b_reg   <= 1'b0;
            busy_reg    <= 1'b0;
        end
        else
        begin
            pos_a_reg   <= pos_a_next;
            pos_b_reg   <= pos_b_next;
            mag_a_reg   <= mag_a_next;
            mag_b_reg   <= mag_b_next;
            total_reg   <= total_next;
            iter_reg    <= iter_next;
            accum_a_reg <= accum_a_next;
            accum_b_reg <= accum_b_next;
            tick_reg    <= tick_next;
            dir_a_reg   <= dir_a_next;
            dir_b_reg   <= dir_b_next;
            busy_reg    <= busy_next;
        end
    end

    `TADSG_ASSERT_NOW(a_iter_below_total, clk, rst_n, busy_reg, iter_reg < total_reg, "iteration count reached total while busy")
    `TADSG_ASSERT_NOW(a_accum_below_total, clk, rst_n, busy_reg, (accum_a_reg < total_reg) && (accum_b_reg < total_reg), "accumulator not below total while busy")
    `TADSG_ASSERT_NEXT(a_done_goes_idle, clk, rst_n, ctrl.fire && result.move_done, !busy_reg, "still busy after move done")
    `TADSG_ASSERT_NEXT(a_reject_keeps_pos, clk, rst_n, ctrl.fire && result.rejected, $stable(pos_a_reg) && $stable(pos_b_reg) && busy_reg, "rejected move changed state")

endmodule

// ----- test/tb_two_axis_dda_step_generator_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_axis_dda_step_generator_top
// Self-checking bench for the two-axis dda step generator. A tracker class
// mirrors the accumulators, tick timer and positions, predicts one output
// word per accepted input word and compares every output field in order.
// Directed moves cover the reset interval, interval zero, rejection and zero
// moves, then random move and tick streams run under bursty input, patterned
// output stalls and one long output hold-off; the largest interval runs last.
// ----------------------------------------------------------------------------
module tb_two_axis_dda_step_generator_top;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam logic [tadsg_pkg::CFG_BITS-1:0] PHASE_INTERVALS [5] =
        '{16'd2, 16'd1, 16'd3, 16'd0, 16'd6};

    class dda_tracker;
        logic [31:0] pos_a;
        logic [31:0] pos_b;
        logic [23:0] mag_a;
        logic [23:0] mag_b;
        logic [23:0] total_iter;
        logic [23:0] iter_done;
        logic [23:0] acc_a;
        logic [23:0] acc_b;
        logic [15:0] elapsed;
        logic [15:0] interval;
        logic        dir_a;
        logic        dir_b;
        logic        busy;
        tadsg_pkg::out_word_t step_outputs[$];
        int          fault_count;

        function new();
            pos_a       = '0;
            pos_b       = '0;
            mag_a       = '0;
            mag_b       = '0;
            total_iter  = '0;
            iter_done   = '0;
            acc_a       = '0;
            acc_b       = '0;
            elapsed     = '0;
            interval    = tadsg_pkg::STEP_INTERVAL_RESET;
            dir_a       = 1'b0;
            dir_b       = 1'b0;
            busy        = 1'b0;
            fault_count = 0;
        endfunction

        function void set_interval(input logic [15:0] value);
            interval = value;
        endfunction

        function void split_count(input logic [23:0] raw, output logic [23:0] mag,
                                  output logic dir);
            if (raw[23])
            begin
                mag = -raw;
                dir = 1'b0;
            end
            else
            begin
                mag = raw;
                dir = 1'b1;
            end
        endfunction

        function void take_command(input tadsg_pkg::in_word_t w);
            tadsg_pkg::out_word_t e;
            logic        was_busy;
            logic [23:0] ma;
            logic [23:0] mb;
            logic        da;
            logic        db;
            logic [24:0] sum;
            e = '0;
            was_busy = busy;
            if (w.kind == tadsg_pkg::KIND_MOVE)
            begin
                if (busy)
                begin
                    e.rejected = 1'b1;
                end
                else
                begin
                    split_count(w.steps_a, ma, da);
                    split_count(w.steps_b, mb, db);
                    if (ma == 0 && mb == 0)
                    begin
                        e.move_done = 1'b1;
                    end
                    else
                    begin
                        mag_a      = ma;
                        mag_b      = mb;
                        dir_a      = da;
                        dir_b      = db;
                        total_iter = (ma > mb) ? ma : mb;
                        iter_done  = '0;
                        acc_a      = '0;
                        acc_b      = '0;
                        elapsed    = '0;
                        busy       = 1'b1;
                    end
                end
            end
            else if (busy)
            begin
                if ({1'b0, elapsed} + 17'd1 >= {1'b0, interval})
                begin
                    elapsed = '0;
                    sum = acc_a + mag_a;
                    if (sum >= total_iter)
                    begin
                        sum = sum - total_iter;
                        e.step_a = 1'b1;
                        pos_a = dir_a ? pos_a + 32'd1 : pos_a - 32'd1;
                    end
                    acc_a = sum[23:0];
                    sum = acc_b + mag_b;
                    if (sum >= total_iter)
                    begin
                        sum = sum - total_iter;
                        e.step_b = 1'b1;
                        pos_b = dir_b ? pos_b + 32'd1 : pos_b - 32'd1;
                    end
                    acc_b = sum[23:0];
                    iter_done = iter_done + 24'd1;
                    if (iter_done >= total_iter)
                    begin
                        busy = 1'b0;
                        e.move_done = 1'b1;
                    end
                end
                else
                begin
                    elapsed = elapsed + 16'd1;
                end
            end
            e.dir_a        = dir_a;
            e.dir_b        = dir_b;
            e.drive_enable = was_busy | busy;
            e.position_a   = pos_a;
            e.position_b   = pos_b;
            step_outputs.push_back(e);
        endfunction

        function void check_field(input string name, input logic [31:0] e,
                                  input logic [31:0] g);
            if (g !== e)
            begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, e, g);
                fault_count++;
            end
        endfunction

        function void compare_output(input tadsg_pkg::out_word_t got);
            tadsg_pkg::out_word_t e;
            if (step_outputs.size() == 0)
            begin
                $error("output word arrived with nothing pending");
                fault_count++;
                return;
            end
            e = step_outputs.pop_front();
            check_field("step_a", e.step_a, got.step_a);
            check_field("step_b", e.step_b, got.step_b);
            check_field("dir_a", e.dir_a, got.dir_a);
            check_field("dir_b", e.dir_b, got.dir_b);
            check_field("drive_enable", e.drive_enable, got.drive_enable);
            check_field("position_a", e.position_a, got.position_a);
            check_field("position_b", e.position_b, got.position_b);
            check_field("move_done", e.move_done, got.move_done);
            check_field("rejected", e.rejected, got.rejected);
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    tadsg_pkg::in_word_t            in_word;
    logic                           out_valid;
    logic                           out_stall;
    tadsg_pkg::out_word_t           out_word;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [tadsg_pkg::CFG_BITS-1:0] cfg_data;

    dda_tracker tracker = new();
    int         burst_left;
    int         results_seen;
    longint     cycle_count;

    two_axis_dda_step_generator_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic tadsg_pkg::in_word_t make_word(input logic kind, input int a,
                                                      input int b);
        tadsg_pkg::in_word_t w;
        w.kind    = kind;
        w.steps_a = a[23:0];
        w.steps_b = b[23:0];
        return w;
    endfunction

    function automatic int random_count();
        int r;
        int m;
        r = $urandom_range(0, 19);
        if (r < 2)
            m = 0;
        else if (r < 17)
            m = $urandom_range(1, 9);
        else
            m = $urandom_range(10, 300);
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    task automatic send_word(input tadsg_pkg::in_word_t w);
        int gap;
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.take_command(w);
        burst_left = burst_left - 1;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_tick();
        send_word(make_word(tadsg_pkg::KIND_TICK, $urandom, $urandom));
    endtask

    task automatic tick_until_idle();
        while (tracker.busy)
            send_tick();
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (tracker.step_outputs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_interval(input logic [tadsg_pkg::CFG_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.set_interval(value);
    endtask

    task automatic random_phase(input int target);
        int counted;
        int r;
        counted = 0;
        while (counted < target)
        begin
            r = $urandom_range(0, 99);
            if (!tracker.busy && r < 45)
            begin
                send_word(make_word(tadsg_pkg::KIND_MOVE, random_count(), random_count()));
                counted++;
            end
            else if (tracker.busy && r < 3)
            begin
                send_word(make_word(tadsg_pkg::KIND_MOVE, $urandom, $urandom));
                counted++;
            end
            else
            begin
                if (tracker.busy)
                    counted++;
                send_tick();
            end
        end
        tick_until_idle();
    endtask

    // output side: stall pattern plus one long hold-off
    initial
    begin
        int mode_left;
        int stall_pct;
        int hold;
        mode_left    = 0;
        stall_pct    = 0;
        hold         = 0;
        results_seen = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                tracker.compare_output(out_word);
                results_seen++;
                if (results_seen == 500)
                    hold = 300;
            end
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(20, 200);
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    default: stall_pct = 70;
                endcase
            end
            mode_left--;
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("two_axis_dda_step_generator_top test failed");
        $finish;
    end

    initial
    begin
        in_valid  <= 1'b0;
        in_word   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        burst_left = 1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset interval, idle tick, zero move, reject while busy
        send_word(make_word(tadsg_pkg::KIND_TICK, 8388607, -8388608));
        send_word(make_word(tadsg_pkg::KIND_MOVE, 0, 0));
        send_word(make_word(tadsg_pkg::KIND_MOVE, -1, 1));
        send_word(make_word(tadsg_pkg::KIND_MOVE, 5, 5));
        tick_until_idle();

        wait_idle();
        write_interval(16'd1);
        send_word(make_word(tadsg_pkg::KIND_MOVE, 3, -5));
        tick_until_idle();
        send_word(make_word(tadsg_pkg::KIND_MOVE, -7, 0));
        send_word(make_word(tadsg_pkg::KIND_TICK, -1, 0));
        send_word(make_word(tadsg_pkg::KIND_MOVE, 4, 4));
        tick_until_idle();
        send_word(make_word(tadsg_pkg::KIND_MOVE, 0, -4));
        tick_until_idle();

        wait_idle();
        write_interval(16'd0);
        send_word(make_word(tadsg_pkg::KIND_MOVE, 2, -3));
        tick_until_idle();

        foreach (PHASE_INTERVALS[i])
        begin
            wait_idle();
            write_interval(PHASE_INTERVALS[i]);
            random_phase(70);
        end

        // full-scale counts, then the largest interval, left running at the end
        wait_idle();
        write_interval(16'd1);
        send_word(make_word(tadsg_pkg::KIND_MOVE, -8388608, 8388607));
        repeat (100) send_tick();
        wait_idle();
        write_interval(16'hFFFF);
        repeat (30) send_tick();
        send_word(make_word(tadsg_pkg::KIND_MOVE, 1, -1));
        repeat (10) send_tick();

        wait_idle();
        repeat (8) @(posedge clk);
        if (tracker.fault_count == 0)
            $display("two_axis_dda_step_generator_top test passed");
        else
            $display("two_axis_dda_step_generator_top test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/tadsg_pkg.sv
src/tadsg_core.sv
src/two_axis_dda_step_generator_top.sv
test/tb_two_axis_dda_step_generator_top.sv
